@@ rtl/cam_generation_trigger_defines.svh @@
// assertion macros shared by the trigger block
`ifndef CAM_GENERATION_TRIGGER_DEFINES_SVH
`define CAM_GENERATION_TRIGGER_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define CGT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked while reset is asserted
`define CGT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also covers the reset cycles
`define CGT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cgt_pkg.sv @@
package cgt_pkg;

  // port widths
  localparam int unsigned IN_W   = 144;
  localparam int unsigned OUT_W  = 8;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // heading wraps at 360.0 degrees in tenths
  localparam logic [11:0] HDG_FULL = 12'd3600;

  // register reset values
  localparam logic [15:0] MIN_IVL_RST    = 16'd100;
  localparam logic [15:0] MAX_IVL_RST    = 16'd1000;
  localparam logic [10:0] HDG_THR_RST    = 11'd40;
  localparam logic [15:0] POS_THR_RST    = 16'd400;
  localparam logic [31:0] POS_THR_SQ_RST = 32'd160000;
  localparam logic [13:0] SPD_THR_RST    = 14'd50;
  localparam logic [7:0]  LOW_DYN_RST    = 8'd3;
  localparam logic [7:0]  CNT_SAT        = 8'd255;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_FIXED = 2'd1,
    CAUSE_DYN   = 2'd2,
    CAUSE_IVL   = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    REG_MIN_IVL  = 3'd0,
    REG_MAX_IVL  = 3'd1,
    REG_HDG_THR  = 3'd2,
    REG_POS_THR  = 3'd3,
    REG_SPD_THR  = 3'd4,
    REG_FIXED    = 3'd5,
    REG_CONG_EN  = 3'd6,
    REG_LOW_DYN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] min_ivl;
    logic [15:0] max_ivl;
    logic [10:0] hdg_thr;
    logic [15:0] pos_thr;
    logic [31:0] pos_thr_sq;
    logic [13:0] spd_thr;
    logic        fixed_rate;
    logic        cong_en;
    logic [7:0]  low_dyn_lim;
  } cfg_t;

  typedef struct packed {
    logic [15:0]        congestion_interval_ms;
    logic [11:0]        heading;
    logic [13:0]        speed_cms;
    logic signed [31:0] pos_y_cm;
    logic signed [31:0] pos_x_cm;
    logic [31:0]        now_ms;
  } item_t;

  // kinematics of the last sent message
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [13:0]        speed;
    logic [11:0]        heading;
  } kin_t;

endpackage

@@ rtl/cgt_cfg.sv @@
module cgt_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cgt_pkg::ADDR_W-1:0]  paddr,
  input  logic [cgt_pkg::DATA_W-1:0]  pwdata,
  output logic [cgt_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cgt_pkg::cfg_t               cfg
);

  cgt_pkg::cfg_t    cfg_r;
  cgt_pkg::cfg_t    cfg_nxt;
  cgt_pkg::reg_idx_t idx;
  logic             wr_en;
  logic [31:0]      thr_sq;

  assign idx    = cgt_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign thr_sq = 32'(pwdata[15:0]) * 32'(pwdata[15:0]);

  // register write decode, threshold square kept alongside the threshold
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        cgt_pkg::REG_MIN_IVL: cfg_nxt.min_ivl = pwdata[15:0];
        cgt_pkg::REG_MAX_IVL: cfg_nxt.max_ivl = pwdata[15:0];
        cgt_pkg::REG_HDG_THR: cfg_nxt.hdg_thr = pwdata[10:0];
        cgt_pkg::REG_POS_THR: begin
          cfg_nxt.pos_thr    = pwdata[15:0];
          cfg_nxt.pos_thr_sq = thr_sq;
        end
        cgt_pkg::REG_SPD_THR: cfg_nxt.spd_thr = pwdata[13:0];
        cgt_pkg::REG_FIXED:   cfg_nxt.fixed_rate = pwdata[0];
        cgt_pkg::REG_CONG_EN: cfg_nxt.cong_en = pwdata[0];
        cgt_pkg::REG_LOW_DYN: cfg_nxt.low_dyn_lim = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_ivl     <= cgt_pkg::MIN_IVL_RST;
      cfg_r.max_ivl     <= cgt_pkg::MAX_IVL_RST;
      cfg_r.hdg_thr     <= cgt_pkg::HDG_THR_RST;
      cfg_r.pos_thr     <= cgt_pkg::POS_THR_RST;
      cfg_r.pos_thr_sq  <= cgt_pkg::POS_THR_SQ_RST;
      cfg_r.spd_thr     <= cgt_pkg::SPD_THR_RST;
      cfg_r.fixed_rate  <= 1'b0;
      cfg_r.cong_en     <= 1'b0;
      cfg_r.low_dyn_lim <= cgt_pkg::LOW_DYN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      cgt_pkg::REG_MIN_IVL: prdata = 32'(cfg_r.min_ivl);
      cgt_pkg::REG_MAX_IVL: prdata = 32'(cfg_r.max_ivl);
      cgt_pkg::REG_HDG_THR: prdata = 32'(cfg_r.hdg_thr);
      cgt_pkg::REG_POS_THR: prdata = 32'(cfg_r.pos_thr);
      cgt_pkg::REG_SPD_THR: prdata = 32'(cfg_r.spd_thr);
      cgt_pkg::REG_FIXED:   prdata = 32'(cfg_r.fixed_rate);
      cgt_pkg::REG_CONG_EN: prdata = 32'(cfg_r.cong_en);
      cgt_pkg::REG_LOW_DYN: prdata = 32'(cfg_r.low_dyn_lim);
      default:              prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/cgt_dyn.sv @@
module cgt_dyn (
  input  cgt_pkg::item_t item,
  input  cgt_pkg::kin_t  kin,
  input  cgt_pkg::cfg_t  cfg,
  output logic           moved
);

  logic [11:0]        dh;
  logic [11:0]        dh_wrap;
  logic [11:0]        hdg_lim;
  logic               hdg_moved;
  logic signed [32:0] dx_s;
  logic signed [32:0] dy_s;
  logic [32:0]        dx;
  logic [32:0]        dy;
  logic               far;
  logic [31:0]        sq_x;
  logic [31:0]        sq_y;
  logic [32:0]        dist_sq;
  logic               pos_moved;
  logic [13:0]        ds;
  logic               spd_moved;

  // heading difference folded into one turn
  assign dh        = (item.heading >= kin.heading) ? item.heading - kin.heading
                                                   : kin.heading - item.heading;
  assign dh_wrap   = (dh >= cgt_pkg::HDG_FULL) ? dh - cgt_pkg::HDG_FULL : dh;
  assign hdg_lim   = cgt_pkg::HDG_FULL - {1'b0, cfg.hdg_thr};
  assign hdg_moved = (dh_wrap > {1'b0, cfg.hdg_thr}) && (dh_wrap < hdg_lim);

  // position distance, exact in integers
  assign dx_s = {item.pos_x_cm[31], item.pos_x_cm} - {kin.x[31], kin.x};
  assign dy_s = {item.pos_y_cm[31], item.pos_y_cm} - {kin.y[31], kin.y};
  assign dx   = dx_s[32] ? 33'(-dx_s) : 33'(dx_s);
  assign dy   = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
  // a difference of 2^16 or more alone beats any 16-bit threshold squared
  assign far  = (|dx[32:16]) || (|dy[32:16]);
  assign sq_x = 32'(dx[15:0]) * 32'(dx[15:0]);
  assign sq_y = 32'(dy[15:0]) * 32'(dy[15:0]);
  assign dist_sq   = 33'(sq_x) + 33'(sq_y);
  assign pos_moved = far || (dist_sq > 33'(cfg.pos_thr_sq));

  // speed change
  assign ds        = (item.speed_cms >= kin.speed) ? item.speed_cms - kin.speed
                                                   : kin.speed - item.speed_cms;
  assign spd_moved = ds > cfg.spd_thr;

  assign moved = hdg_moved || pos_moved || spd_moved;

endmodule

@@ rtl/cgt_core.sv @@
module cgt_core (
  input  logic              clk,
  input  logic              rst_n,
  input  cgt_pkg::cfg_t     cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cgt_pkg::item_t    in_item,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_send,
  output cgt_pkg::cause_t   out_cause
);

  logic             in_v_r;
  cgt_pkg::item_t   item_r;
  logic             out_v_r;
  logic             send_r;
  cgt_pkg::cause_t  cause_r;

  cgt_pkg::kin_t    kin_r;
  logic [31:0]      last_time_r;
  logic [15:0]      cur_ivl_r;
  logic [7:0]       cnt_r;

  cgt_pkg::kin_t    kin_nxt;
  logic [31:0]      last_time_nxt;
  logic [15:0]      cur_ivl_nxt;
  logic [7:0]       cnt_nxt;
  cgt_pkg::cause_t  cause_nxt;

  logic             out_free;
  logic             adv;
  logic             in_xfer;
  logic             moved;
  logic [31:0]      elapsed;
  logic [15:0]      clamp_lo;
  logic [15:0]      floor_ivl;
  logic [7:0]       cnt_inc;

  // handshake: the result register frees up as the next item moves in
  assign out_free  = !out_v_r || out_tready;
  assign adv       = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  cgt_dyn u_dyn (
    .item  (item_r),
    .kin   (kin_r),
    .cfg   (cfg),
    .moved (moved)
  );

  // floor interval and elapsed time
  assign elapsed   = item_r.now_ms - last_time_r;
  assign clamp_lo  = (item_r.congestion_interval_ms < cfg.min_ivl) ? cfg.min_ivl
                                                                   : item_r.congestion_interval_ms;
  assign floor_ivl = !cfg.cong_en ? cfg.min_ivl
                   : (clamp_lo > cfg.max_ivl) ? cfg.max_ivl : clamp_lo;
  assign cnt_inc   = (cnt_r == cgt_pkg::CNT_SAT) ? cnt_r : cnt_r + 8'd1;

  // send decision and adaptive state update
  always_comb begin
    cause_nxt     = cgt_pkg::CAUSE_NONE;
    cur_ivl_nxt   = cur_ivl_r;
    cnt_nxt       = cnt_r;
    kin_nxt       = kin_r;
    last_time_nxt = last_time_r;
    if (elapsed >= 32'(floor_ivl)) begin
      priority if (cfg.fixed_rate) begin
        cause_nxt = cgt_pkg::CAUSE_FIXED;
      end else if (moved) begin
        cause_nxt   = cgt_pkg::CAUSE_DYN;
        cur_ivl_nxt = (elapsed < 32'(cfg.max_ivl)) ? elapsed[15:0] : cfg.max_ivl;
        cnt_nxt     = '0;
      end else if (elapsed >= 32'(cur_ivl_r)) begin
        cause_nxt = cgt_pkg::CAUSE_IVL;
        cnt_nxt   = cnt_inc;
        if (cnt_inc >= cfg.low_dyn_lim) begin
          cur_ivl_nxt = cfg.max_ivl;
        end
      end else begin
        cause_nxt = cgt_pkg::CAUSE_NONE;
      end
    end
    if (cause_nxt != cgt_pkg::CAUSE_NONE) begin
      kin_nxt.x       = item_r.pos_x_cm;
      kin_nxt.y       = item_r.pos_y_cm;
      kin_nxt.speed   = item_r.speed_cms;
      kin_nxt.heading = item_r.heading;
      last_time_nxt   = item_r.now_ms;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= (in_v_r && !adv) || in_xfer;
    end
    if (in_xfer) begin
      item_r <= in_item;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      kin_r       <= '0;
      last_time_r <= '0;
      cur_ivl_r   <= cgt_pkg::MAX_IVL_RST;
      cnt_r       <= '0;
    end else if (adv) begin
      out_v_r     <= 1'b1;
      kin_r       <= kin_nxt;
      last_time_r <= last_time_nxt;
      cur_ivl_r   <= cur_ivl_nxt;
      cnt_r       <= cnt_nxt;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
    if (adv) begin
      send_r  <= (cause_nxt != cgt_pkg::CAUSE_NONE);
      cause_r <= cause_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_send   = send_r;
  assign out_cause  = cause_r;

endmodule

@@ rtl/cam_generation_trigger.sv @@
// pipeline: an item is held in the input register after its input transfer and moves
// on to the result register once that register is free, then leaves by its own transfer
// throughput: one item per cycle unless out_tready stalls; decision and state update
// for an item share one register-to-register path; the next item sees the new state
// reset: synchronous active-low rst_n clears both valid flags and the reference
// kinematics and time, sets the current interval to 1000 ms and registers to defaults
`include "cam_generation_trigger_defines.svh"

module cam_generation_trigger (
  input  logic                        clk,
  input  logic                        rst_n,
  // now_ms[31:0], pos_x_cm[63:32], pos_y_cm[95:64], speed_cms[109:96],
  // heading[121:110], congestion_interval_ms[137:122], zero pad
  input  logic [cgt_pkg::IN_W-1:0]    in_tdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // send[0], cause[2:1], zero pad
  output logic [cgt_pkg::OUT_W-1:0]   out_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cgt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [cgt_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [cgt_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  cgt_pkg::cfg_t    cfg;
  cgt_pkg::item_t   in_item;
  logic             out_send;
  cgt_pkg::cause_t  out_cause;

  // unpack the input transfer
  assign in_item.now_ms                 = in_tdata[31:0];
  assign in_item.pos_x_cm               = in_tdata[63:32];
  assign in_item.pos_y_cm               = in_tdata[95:64];
  assign in_item.speed_cms              = in_tdata[109:96];
  assign in_item.heading                = in_tdata[121:110];
  assign in_item.congestion_interval_ms = in_tdata[137:122];

  cgt_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  cgt_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_send   (out_send),
    .out_cause  (out_cause)
  );

  // pack the result transfer
  assign out_tdata = {5'd0, out_cause, out_send};

  // checks
  `CGT_ASSERT_NOW(a_send_matches_cause, out_tvalid, out_tdata[0] == (out_tdata[2:1] != cgt_pkg::CAUSE_NONE), "send flag disagrees with cause")
  `CGT_ASSERT_NOW(a_ready_when_free, !out_tvalid || out_tready, in_tready, "input stalled while result register is free")
  `CGT_ASSERT_RST(a_reset_clears_out, !rst_n, !out_tvalid, "result valid after reset")
  `CGT_ASSERT_NEXT(a_no_repeat, out_tvalid && out_tready && !u_core.in_v_r, !out_tvalid, "result repeated without a new item")

endmodule
